[src/svm_pkg.sv]
`default_nettype none
package svm_pkg;
	typedef struct packed {
		logic [7:0] req_type;
		logic signed [31:0] operand_first;
		logic signed [31:0] operand_second;
	} req_t;

	typedef struct packed {
		logic signed [31:0] top_value;
		logic signed [31:0] popped_value;
		logic [8:0] stack_level;
		logic signed [31:0] next_ip;
		logic halted;
		logic [2:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_OVERFLOW = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIV_ZERO = 3'd3,
		ST_BAD_REG = 3'd4,
		ST_BAD_OP = 3'd5
	} status_t;

	localparam logic [7:0] OP_HLT = 8'd0;
	localparam logic [7:0] OP_PSH = 8'd1;
	localparam logic [7:0] OP_POP = 8'd2;
	localparam logic [7:0] OP_ADD = 8'd3;
	localparam logic [7:0] OP_MUL = 8'd4;
	localparam logic [7:0] OP_DIV = 8'd5;
	localparam logic [7:0] OP_SUB = 8'd6;
	localparam logic [7:0] OP_MOV = 8'd7;
	localparam logic [7:0] OP_SET = 8'd8;
	localparam logic [7:0] OP_NOP = 8'd9;

	localparam logic [2:0] REG_A = 3'd0;
	localparam logic [2:0] REG_B = 3'd1;
	localparam logic [2:0] REG_C = 3'd2;
	localparam logic [2:0] REG_IP = 3'd6;
	localparam logic [2:0] REG_SP = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CLEAR,
		S_RDA,
		S_RDB,
		S_EXEC,
		S_DIV,
		S_WRITE,
		S_TOP,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic clr_step;
		logic rd_a;
		logic rd_b;
		logic exec;
		logic div_start;
		logic commit;
		logic rd_top;
		logic make_rsp;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic err;
		logic halted;
		logic is_arith;
		logic is_div;
		logic div_busy;
	} sts_t;
endpackage
`default_nettype wire

[src/svm_div.sv]
`default_nettype none
module svm_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [31:0] dividend,
	input  wire logic [31:0] divisor,
	output logic busy,
	output logic [31:0] quotient
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, den_q};
	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (32'd0 - dividend) : dividend;
			den_q <= divisor[31] ? (32'd0 - divisor) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[src/svm_ctrl.sv]
`default_nettype none
module svm_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire svm_pkg::sts_t sts,
	output svm_pkg::cmd_t cmd
);
	svm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svm_pkg::S_CLEAR;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.make_rsp) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign in_ready = state_q == svm_pkg::S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			svm_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					state_d = svm_pkg::S_IDLE;
				end
			end
			svm_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = svm_pkg::S_CHECK;
				end
			end
			svm_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.halted || sts.err) begin
					state_d = svm_pkg::S_TOP;
				end else if (sts.is_arith) begin
					cmd.rd_a = 1'b1;
					state_d = svm_pkg::S_RDA;
				end else begin
					state_d = svm_pkg::S_EXEC;
				end
			end
			svm_pkg::S_RDA: begin
				cmd.rd_b = 1'b1;
				state_d = svm_pkg::S_RDB;
			end
			svm_pkg::S_RDB: begin
				if (sts.is_div) begin
					cmd.div_start = 1'b1;
					state_d = svm_pkg::S_DIV;
				end else begin
					state_d = svm_pkg::S_EXEC;
				end
			end
			svm_pkg::S_DIV: begin
				if (!sts.div_busy) begin
					state_d = svm_pkg::S_EXEC;
				end
			end
			svm_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = svm_pkg::S_WRITE;
			end
			svm_pkg::S_WRITE: begin
				cmd.commit = 1'b1;
				state_d = svm_pkg::S_TOP;
			end
			svm_pkg::S_TOP: begin
				cmd.rd_top = 1'b1;
				state_d = svm_pkg::S_RESP;
			end
			svm_pkg::S_RESP: begin
				if (!out_valid || out_ready) begin
					cmd.make_rsp = 1'b1;
					state_d = svm_pkg::S_IDLE;
				end
			end
			default: state_d = svm_pkg::S_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.make_rsp |=> out_valid)
		else $error("response not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second transaction taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");
endmodule
`default_nettype wire

[src/svm_dp.sv]
`default_nettype none
module svm_dp #(
	parameter int STACK_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire svm_pkg::req_t req,
	input  wire svm_pkg::cmd_t cmd,
	output svm_pkg::sts_t sts,
	output svm_pkg::rsp_t rsp
);
	localparam int AW = $clog2(STACK_DEPTH);

	svm_pkg::req_t req_q;
	logic [31:0] regs_q [8];
	logic halted_q;
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_q, a_q, b_q, c_q, popped_q;
	logic [AW-1:0] clr_q;
	logic [2:0] status_q;
	logic [31:0] sp, ip;
	logic signed [33:0] sps;
	logic [31:0] prod;
	logic [31:0] quo;
	logic div_busy;
	logic [7:0] op;
	logic arith, is_psh, is_pop;
	logic [2:0] chk;
	logic signed [33:0] lvl;
	logic [AW-1:0] raddr;
	logic do_wr;
	logic [AW-1:0] waddr;
	logic [31:0] wdata;

	assign op = req_q.req_type;
	assign sp = regs_q[svm_pkg::REG_SP];
	assign ip = regs_q[svm_pkg::REG_IP];
	assign sps = 34'(signed'(sp));
	assign arith = op == svm_pkg::OP_ADD || op == svm_pkg::OP_MUL
		|| op == svm_pkg::OP_DIV || op == svm_pkg::OP_SUB;
	assign is_psh = op == svm_pkg::OP_PSH;
	assign is_pop = op == svm_pkg::OP_POP;

	always_comb begin
		chk = svm_pkg::ST_OK;
		if (is_psh) begin
			if (sps >= 34'(STACK_DEPTH - 1)) chk = svm_pkg::ST_OVERFLOW;
			else if (sps < -34'sd1) chk = svm_pkg::ST_UNDERFLOW;
		end else if (is_pop || arith) begin
			if (sps > 34'(STACK_DEPTH - 1)) chk = svm_pkg::ST_OVERFLOW;
			else if (sps < (is_pop ? 34'sd0 : 34'sd1)) chk = svm_pkg::ST_UNDERFLOW;
		end else if (op == svm_pkg::OP_MOV) begin
			if (req_q.operand_first[31:3] != '0 || req_q.operand_second[31:3] != '0)
				chk = svm_pkg::ST_BAD_REG;
		end else if (op == svm_pkg::OP_SET) begin
			if (req_q.operand_first[31:3] != '0) chk = svm_pkg::ST_BAD_REG;
		end else if (op > svm_pkg::OP_NOP) begin
			chk = svm_pkg::ST_BAD_OP;
		end
	end

	assign sts.clr_done = clr_q == AW'(STACK_DEPTH - 1);
	assign sts.err = chk != svm_pkg::ST_OK;
	assign sts.halted = halted_q;
	assign sts.is_arith = arith;
	assign sts.is_div = op == svm_pkg::OP_DIV;
	assign sts.div_busy = div_busy;

	svm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(b_q), .divisor(a_q), .busy(div_busy), .quotient(quo)
	);

	assign prod = a_q * b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < 8; i++)
				regs_q[i] <= (3'(i) == svm_pkg::REG_SP) ? 32'hffff_ffff : 32'd0;
			status_q <= svm_pkg::ST_OK;
			popped_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.load) begin
				status_q <= svm_pkg::ST_OK;
				popped_q <= '0;
			end
			if (cmd.check) status_q <= halted_q ? svm_pkg::ST_OK : chk;
			if (cmd.exec) begin
				if (op == svm_pkg::OP_DIV && a_q == '0) status_q <= svm_pkg::ST_DIV_ZERO;
			end
			if (cmd.commit && status_q == svm_pkg::ST_OK) begin
				unique case (op)
					svm_pkg::OP_HLT: begin
						halted_q <= 1'b1;
						regs_q[svm_pkg::REG_IP] <= ip + 32'd1;
					end
					svm_pkg::OP_PSH: begin
						regs_q[svm_pkg::REG_SP] <= sp + 32'd1;
						regs_q[svm_pkg::REG_IP] <= ip + 32'd2;
					end
					svm_pkg::OP_POP: begin
						popped_q <= rd_q;
						regs_q[svm_pkg::REG_SP] <= sp - 32'd1;
						regs_q[svm_pkg::REG_IP] <= ip + 32'd1;
					end
					svm_pkg::OP_ADD, svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_SUB: begin
						regs_q[svm_pkg::REG_A] <= a_q;
						regs_q[svm_pkg::REG_B] <= b_q;
						regs_q[svm_pkg::REG_C] <= c_q;
						regs_q[svm_pkg::REG_SP] <= sp - 32'd1;
						regs_q[svm_pkg::REG_IP] <= ip + 32'd1;
					end
					svm_pkg::OP_MOV: begin
						if (req_q.operand_second[2:0] == svm_pkg::REG_IP)
							regs_q[svm_pkg::REG_IP] <= regs_q[req_q.operand_first[2:0]] + 32'd3;
						else begin
							regs_q[req_q.operand_second[2:0]] <= regs_q[req_q.operand_first[2:0]];
							regs_q[svm_pkg::REG_IP] <= ip + 32'd3;
						end
					end
					svm_pkg::OP_SET: begin
						if (req_q.operand_first[2:0] == svm_pkg::REG_IP)
							regs_q[svm_pkg::REG_IP] <= req_q.operand_second + 32'd3;
						else begin
							regs_q[req_q.operand_first[2:0]] <= req_q.operand_second;
							regs_q[svm_pkg::REG_IP] <= ip + 32'd3;
						end
					end
					default: regs_q[svm_pkg::REG_IP] <= ip + 32'd1;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.exec) begin
			unique case (op)
				svm_pkg::OP_ADD: c_q <= b_q + a_q;
				svm_pkg::OP_SUB: c_q <= b_q - a_q;
				svm_pkg::OP_MUL: c_q <= prod;
				default: c_q <= quo;
			endcase
		end
		if (cmd.rd_a) a_q <= rd_q;
		if (cmd.rd_b) b_q <= rd_q;
	end

	always_comb begin
		raddr = sp[AW-1:0];
		if (cmd.rd_a) raddr = AW'(sp - 32'd1);
		if (cmd.rd_top) raddr = sp[AW-1:0];
	end

	always_comb begin
		do_wr = 1'b0;
		waddr = clr_q;
		wdata = '0;
		if (cmd.clr_step) begin
			do_wr = 1'b1;
		end else if (cmd.commit && status_q == svm_pkg::ST_OK && !halted_q) begin
			if (is_psh) begin
				do_wr = 1'b1;
				waddr = AW'(sp + 32'd1);
				wdata = req_q.operand_first;
			end else if (arith) begin
				do_wr = 1'b1;
				waddr = AW'(sp - 32'd1);
				wdata = c_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign lvl = sps + 34'sd1;
	always_comb begin
		rsp.top_value = (sps >= 0 && sps < 34'(STACK_DEPTH)) ? rd_q : '0;
		rsp.popped_value = popped_q;
		if (lvl < 0) rsp.stack_level = '0;
		else if (lvl > 34'(STACK_DEPTH)) rsp.stack_level = (STACK_DEPTH > 511) ? 9'd511
			: 9'(STACK_DEPTH);
		else if (lvl > 34'sd511) rsp.stack_level = 9'd511;
		else rsp.stack_level = lvl[8:0];
		rsp.next_ip = ip;
		rsp.halted = halted_q;
		rsp.status = status_q;
	end
endmodule
`default_nettype wire

[src/stack_vm_instruction_step.sv]
// Path: a halted or rejected transaction goes from the check straight to the top-of-stack
// read and the response; hlt, psh, pop, mov, set and nop pass execute and write first;
// add, sub and mul also read both operands, and div then waits for the 32-step divider.
// Flow: one transaction at a time; the next is accepted once the result is loaded, and
// a result waits while the one before is not taken. Reset: registers zero, SP all ones,
// halt clear; then a clearing pass zeroes the stack before any transaction is accepted.
`default_nettype none
module stack_vm_instruction_step #(
	parameter int STACK_DEPTH = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire svm_pkg::req_t in_data,
	output logic out_valid,
	input  wire logic out_ready,
	output svm_pkg::rsp_t out_data
);
	svm_pkg::cmd_t cmd;
	svm_pkg::sts_t sts;
	svm_pkg::rsp_t rsp;
	svm_pkg::rsp_t out_q;

	svm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	svm_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(in_data), .cmd(cmd), .sts(sts), .rsp(rsp)
	);

	always_ff @(posedge clk) begin
		if (cmd.make_rsp) out_q <= rsp;
	end
	assign out_data = out_q;
endmodule
`default_nettype wire

[sim/tb_stack_vm_instruction_step.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_stack_vm_instruction_step;
	localparam int DEPTH = 256;
	localparam int NUM_REGS = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	svm_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	svm_pkg::rsp_t out_data;

	stack_vm_instruction_step #(.STACK_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] vm_regs [NUM_REGS];
	logic [31:0] vm_stack [DEPTH];
	logic vm_halted;

	svm_pkg::req_t pending_instrs [$];
	svm_pkg::rsp_t expected_steps [$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit in_fire = 1'b0;
	int hold_off = 0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic longint sx(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic svm_pkg::rsp_t execute_instr(svm_pkg::req_t r);
		svm_pkg::rsp_t o;
		logic [31:0] o1, o2, a, b, c, ip;
		longint sp, lvl;
		svm_pkg::status_t st;
		logic [31:0] popped;
		o1 = r.operand_first;
		o2 = r.operand_second;
		popped = '0;
		st = svm_pkg::ST_OK;
		sp = sx(vm_regs[svm_pkg::REG_SP]);
		ip = vm_regs[svm_pkg::REG_IP];
		if (!vm_halted) begin
			case (r.req_type)
				svm_pkg::OP_HLT: begin
					vm_halted = 1'b1;
					vm_regs[svm_pkg::REG_IP] = ip + 32'd1;
				end
				svm_pkg::OP_PSH: begin
					if (sp >= DEPTH - 1) st = svm_pkg::ST_OVERFLOW;
					else if (sp < -1) st = svm_pkg::ST_UNDERFLOW;
					else begin
						vm_stack[sp + 1] = o1;
						vm_regs[svm_pkg::REG_SP] = 32'(sp + 1);
						vm_regs[svm_pkg::REG_IP] = ip + 32'd2;
					end
				end
				svm_pkg::OP_POP: begin
					if (sp > DEPTH - 1) st = svm_pkg::ST_OVERFLOW;
					else if (sp < 0) st = svm_pkg::ST_UNDERFLOW;
					else begin
						popped = vm_stack[sp];
						vm_regs[svm_pkg::REG_SP] = 32'(sp - 1);
						vm_regs[svm_pkg::REG_IP] = ip + 32'd1;
					end
				end
				svm_pkg::OP_ADD, svm_pkg::OP_MUL, svm_pkg::OP_DIV, svm_pkg::OP_SUB: begin
					if (sp > DEPTH - 1) st = svm_pkg::ST_OVERFLOW;
					else if (sp < 1) st = svm_pkg::ST_UNDERFLOW;
					else begin
						a = vm_stack[sp];
						b = vm_stack[sp - 1];
						c = '0;
						if (r.req_type == svm_pkg::OP_ADD) c = b + a;
						else if (r.req_type == svm_pkg::OP_MUL) c = b * a;
						else if (r.req_type == svm_pkg::OP_SUB) c = b - a;
						else if (a == 0) st = svm_pkg::ST_DIV_ZERO;
						else c = 32'(sx(b) / sx(a));
						if (st == svm_pkg::ST_OK) begin
							vm_regs[svm_pkg::REG_A] = a;
							vm_regs[svm_pkg::REG_B] = b;
							vm_regs[svm_pkg::REG_C] = c;
							vm_stack[sp - 1] = c;
							vm_regs[svm_pkg::REG_SP] = 32'(sp - 1);
							vm_regs[svm_pkg::REG_IP] = ip + 32'd1;
						end
					end
				end
				svm_pkg::OP_MOV: begin
					if (o1 >= NUM_REGS || o2 >= NUM_REGS) st = svm_pkg::ST_BAD_REG;
					else begin
						vm_regs[o2[2:0]] = vm_regs[o1[2:0]];
						vm_regs[svm_pkg::REG_IP] = vm_regs[svm_pkg::REG_IP] + 32'd3;
					end
				end
				svm_pkg::OP_SET: begin
					if (o1 >= NUM_REGS) st = svm_pkg::ST_BAD_REG;
					else begin
						vm_regs[o1[2:0]] = o2;
						vm_regs[svm_pkg::REG_IP] = vm_regs[svm_pkg::REG_IP] + 32'd3;
					end
				end
				svm_pkg::OP_NOP: vm_regs[svm_pkg::REG_IP] = ip + 32'd1;
				default: st = svm_pkg::ST_BAD_OP;
			endcase
		end
		sp = sx(vm_regs[svm_pkg::REG_SP]);
		o.top_value = (sp >= 0 && sp < DEPTH) ? vm_stack[sp] : '0;
		o.popped_value = popped;
		lvl = sp + 1;
		if (lvl < 0) lvl = 0;
		if (lvl > DEPTH) lvl = DEPTH;
		if (lvl > 511) lvl = 511;
		o.stack_level = 9'(lvl);
		o.next_ip = vm_regs[svm_pkg::REG_IP];
		o.halted = vm_halted;
		o.status = st;
		return o;
	endfunction

	function automatic svm_pkg::req_t make_instr(logic [7:0] op, logic [31:0] f,
			logic [31:0] s);
		svm_pkg::req_t r;
		r.req_type = op;
		r.operand_first = f;
		r.operand_second = s;
		return r;
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom();
		endcase
	endfunction

	function automatic svm_pkg::req_t rand_instr();
		logic [7:0] op;
		logic [31:0] f, s;
		int k;
		k = $urandom_range(0, 99);
		f = rand_value();
		s = rand_value();
		if (k < 28) op = svm_pkg::OP_PSH;
		else if (k < 36) op = svm_pkg::OP_POP;
		else if (k < 44) op = svm_pkg::OP_ADD;
		else if (k < 50) op = svm_pkg::OP_MUL;
		else if (k < 58) op = svm_pkg::OP_DIV;
		else if (k < 64) op = svm_pkg::OP_SUB;
		else if (k < 74) begin
			op = svm_pkg::OP_MOV;
			if ($urandom_range(0, 9) != 0) begin
				f = $urandom_range(0, 7);
				s = $urandom_range(0, 5);
			end
		end else if (k < 88) begin
			op = svm_pkg::OP_SET;
			if ($urandom_range(0, 9) != 0) begin
				f = $urandom_range(0, 7);
				if (f == svm_pkg::REG_SP) s = 32'(int'($urandom_range(0, DEPTH + 2)) - 3);
			end
		end else if (k < 95) op = svm_pkg::OP_NOP;
		else op = 8'($urandom_range(10, 255));
		return make_instr(op, f, s);
	endfunction

	initial begin
		for (int i = 0; i < NUM_REGS; i++) vm_regs[i] = '0;
		vm_regs[svm_pkg::REG_SP] = '1;
		for (int i = 0; i < DEPTH; i++) vm_stack[i] = '0;
		vm_halted = 1'b0;

		pending_instrs.push_back(make_instr(svm_pkg::OP_POP, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_ADD, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'h8000_0000, 32'hffff_ffff));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'hffff_ffff, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_DIV, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_DIV, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'h7fff_ffff, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_MUL, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'd7, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SUB, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'hffff_fff9, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_DIV, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_POP, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_MOV, svm_pkg::REG_SP, svm_pkg::REG_A));
		pending_instrs.push_back(make_instr(svm_pkg::OP_MOV, svm_pkg::REG_IP, svm_pkg::REG_IP));
		pending_instrs.push_back(make_instr(svm_pkg::OP_MOV, 32'd8, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_MOV, 0, 32'hffff_ffff));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, 32'h8000_0000, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, svm_pkg::REG_IP, 32'hffff_fffe));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, svm_pkg::REG_SP, 32'hffff_fff0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 1, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, svm_pkg::REG_SP, 32'd300));
		pending_instrs.push_back(make_instr(svm_pkg::OP_POP, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, svm_pkg::REG_SP, 32'd254));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 32'h1234_5678, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_SET, svm_pkg::REG_SP, 32'hffff_ffff));
		pending_instrs.push_back(make_instr(svm_pkg::OP_NOP, 0, 0));
		pending_instrs.push_back(make_instr(8'hff, 0, 0));
		pending_instrs.push_back(make_instr(8'd10, 0, 0));
		for (int i = 0; i < 1500; i++) pending_instrs.push_back(rand_instr());
		pending_instrs.push_back(make_instr(svm_pkg::OP_HLT, 0, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_PSH, 5, 0));
		pending_instrs.push_back(make_instr(svm_pkg::OP_POP, 0, 0));
		pending_instrs.push_back(make_instr(8'hff, 0, 0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (in_valid && in_ready) begin
			expected_steps.push_back(execute_instr(in_data));
			if (pending_instrs.size() < 150) calm <= 1'b1;
		end
		if (out_valid && out_ready) begin
			if (expected_steps.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < 10) $display("unexpected transaction %p", out_data);
			end else begin
				svm_pkg::rsp_t exp_rsp;
				exp_rsp = expected_steps.pop_front();
				if (out_data !== exp_rsp) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display("mismatch: expected %p actual %p", exp_rsp, out_data);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_fire) begin
			end else if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_instrs.size() > 0
					&& (in_valid || calm || $urandom_range(0, 3) != 0)) begin
				if (!in_valid && !calm && $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(1, 4);
					in_valid <= 1'b0;
				end else begin
					in_data <= pending_instrs.pop_front();
					in_valid <= 1'b1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (cycle_count == 3000) begin
				hold_off <= 400;
				out_ready <= 1'b0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= (hold_off == 1);
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ready <= (recv_gap == 1);
			end else if (!calm && $urandom_range(0, 6) == 0) begin
				recv_gap <= $urandom_range(1, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		wait (arst_n);
		while ((pending_instrs.size() > 0 || in_valid || expected_steps.size() > 0)
				&& cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			repeat (60) @(posedge clk);
			if (mismatch_count == 0 && expected_steps.size() == 0) $display("SUCCESS");
			else $display("FAILURE");
			$finish;
		end
	end
endmodule
`default_nettype wire
